// ===== rtl/sha1h_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_pkg: shared types and constants of the SHA-1 hasher
// Sequencer states, return codes after a compression, control groups and
// the round and initial-value constants.
// ----------------------------------------------------------------------------
package sha1h_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD
  } state_t;

  // where the sequencer goes once a block has been folded in
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_MARK,
    RET_ZERO,
    RET_DONE
  } ret_t;

  typedef struct packed {
    logic load;    // copy chaining value into the working variables
    logic round;   // advance the working variables by one round
    logic fold;    // add the working variables into the chaining value
    logic reinit;  // with fold: restore the initial value instead
  } core_ctrl_t;

  typedef struct packed {
    logic push;    // shift one byte into the block window
    logic step;    // advance the schedule window by one word
    logic expand;  // rounds 16 and up: use the expanded word
  } sched_ctrl_t;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] EXPAND_FROM = 7'd16;
  localparam logic [6:0] PHASE1      = 7'd20;
  localparam logic [6:0] PHASE2      = 7'd40;
  localparam logic [6:0] PHASE3      = 7'd60;

endpackage
`default_nettype wire

// ===== rtl/sha1h_sched.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_sched: block window and message schedule
// Collects bytes into a 16-word window, then supplies one schedule word per
// round, expanding by XOR and rotate-by-one from round 16 on.
// ----------------------------------------------------------------------------
module sha1h_sched import sha1h_pkg::*; (
  input  wire         clk,
  input  sched_ctrl_t ctrl,
  input  wire  [7:0]  byte_in,
  output word_t       w
);

  word_t win [16];
  word_t x;

  always_comb begin
    x = win[13] ^ win[8] ^ win[2] ^ win[0];
    w = ctrl.expand ? {x[30:0], x[31]} : win[0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= {win[k][23:0], win[k+1][31:24]};
      end
      win[15] <= {win[15][23:0], byte_in};
    end else if (ctrl.step) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= win[k+1];
      end
      win[15] <= w;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sha1h_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_core: shared round unit and chaining value
// One SHA-1 round per cycle on the working variables; fold adds them into
// the chaining value at the end of a block.
// ----------------------------------------------------------------------------
module sha1h_core import sha1h_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  core_ctrl_t        ctrl,
  input  wire  [6:0]        rnd,
  input  word_t             w,
  output logic [4:0][31:0]  sum
);

  word_t cv [5];
  word_t wv [5];
  word_t f;
  word_t k;
  word_t tmp;

  always_comb begin
    if (rnd < PHASE1) begin
      f = (wv[1] & wv[2]) | (~wv[1] & wv[3]);
      k = K0;
    end else if (rnd < PHASE2) begin
      f = wv[1] ^ wv[2] ^ wv[3];
      k = K1;
    end else if (rnd < PHASE3) begin
      f = (wv[1] & wv[2]) | (wv[1] & wv[3]) | (wv[2] & wv[3]);
      k = K2;
    end else begin
      f = wv[1] ^ wv[2] ^ wv[3];
      k = K3;
    end
    tmp = {wv[0][26:0], wv[0][31:27]} + f + wv[4] + k + w;
    for (int i = 0; i < 5; i++) begin
      sum[i] = cv[i] + wv[i];
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        cv[i] <= IV[i];
      end
    end else if (ctrl.fold) begin
      for (int i = 0; i < 5; i++) begin
        cv[i] <= ctrl.reinit ? IV[i] : sum[i];
      end
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 5; i++) begin
        wv[i] <= cv[i];
      end
    end else if (ctrl.round) begin
      wv[0] <= tmp;
      wv[1] <= wv[0];
      wv[2] <= {wv[1][1:0], wv[1][31:2]};
      wv[3] <= wv[2];
      wv[4] <= wv[3];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sha1_hasher.sv =====
`default_nettype none
// A byte that does not complete a block is taken as it arrives; a byte that
// completes one holds the input for the compression (load, 80 rounds, fold).
// No input is taken while a block is compressed or while the message is padded.
// Reset (rst, synchronous) clears the sequencer, counts and output valid and
// restores the initial chaining value; the block buffer is left as it is.
// ----------------------------------------------------------------------------
// sha1_hasher: SHA-1 of one byte-serial message
// Input words carry an optional byte and an end-of-message mark; the result
// word carries the 160-bit digest as five big-endian 32-bit words.
// ----------------------------------------------------------------------------
module sha1_hasher import sha1h_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         has_byte,
  input  wire         last,
  output logic        out_valid,
  input  wire         out_ready,
  output word_t       digest_a,
  output word_t       digest_b,
  output word_t       digest_c,
  output word_t       digest_d,
  output word_t       digest_e
);

  state_t       state, state_next;
  ret_t         ret, ret_next;
  logic [5:0]   fill, fill_next;         // bytes held in the current block
  logic [60:0]  byte_count, byte_count_next;
  logic [6:0]   rnd, rnd_next;           // round index during compression
  logic         out_load;

  core_ctrl_t       cctrl;
  sched_ctrl_t      sctrl;
  logic [7:0]       byte_sel;
  logic [63:0]      len_bits;
  logic [7:0]       len_byte;
  word_t            w;
  logic [4:0][31:0] sum;

  // length field in bits, big-endian; fill[2:0] walks its eight bytes
  assign len_bits = {byte_count, 3'b000};
  assign len_byte = len_bits[{~fill[2:0], 3'b000} +: 8];

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret        <= RET_IDLE;
      fill       <= '0;
      byte_count <= '0;
      rnd        <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      fill       <= fill_next;
      byte_count <= byte_count_next;
      rnd        <= rnd_next;
    end
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    fill_next       = fill;
    byte_count_next = byte_count;
    rnd_next        = rnd;
    cctrl           = '0;
    sctrl           = '0;
    byte_sel        = 8'h00;
    out_load        = 1'b0;
    case (state)
      ST_IDLE: begin
        byte_sel = data_byte;
        if (in_valid) begin
          if (has_byte) begin
            sctrl.push      = 1'b1;
            fill_next       = fill + 6'd1;
            byte_count_next = byte_count + 61'd1;
            if (&fill) begin
              // block full: compress, then pad if this was the last word
              state_next = ST_LOAD;
              ret_next   = last ? RET_MARK : RET_IDLE;
            end else if (last) begin
              state_next = ST_MARK;
            end
          end else if (last) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        // append the end-of-message marker byte
        byte_sel   = PAD_BYTE;
        sctrl.push = 1'b1;
        fill_next  = fill + 6'd1;
        if (&fill) begin
          state_next = ST_LOAD;
          ret_next   = RET_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        // zero fill up to the length field, spilling into a new block if needed
        if (fill == LEN_POS) begin
          state_next = ST_LEN;
        end else begin
          sctrl.push = 1'b1;
          fill_next  = fill + 6'd1;
          if (&fill) begin
            state_next = ST_LOAD;
            ret_next   = RET_ZERO;
          end
        end
      end
      ST_LEN: begin
        byte_sel   = len_byte;
        sctrl.push = 1'b1;
        fill_next  = fill + 6'd1;
        if (&fill) begin
          state_next = ST_LOAD;
          ret_next   = RET_DONE;
        end
      end
      ST_LOAD: begin
        cctrl.load = 1'b1;
        rnd_next   = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cctrl.round  = 1'b1;
        sctrl.step   = 1'b1;
        sctrl.expand = (rnd >= EXPAND_FROM);
        rnd_next     = rnd + 7'd1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (ret == RET_DONE) begin
          // hold here until the previous digest has been taken
          if (!out_valid || out_ready) begin
            cctrl.fold      = 1'b1;
            cctrl.reinit    = 1'b1;
            out_load        = 1'b1;
            byte_count_next = '0;
            fill_next       = '0;
            state_next      = ST_IDLE;
          end
        end else begin
          cctrl.fold = 1'b1;
          case (ret)
            RET_MARK: state_next = ST_MARK;
            RET_ZERO: state_next = ST_ZERO;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  sha1h_sched u_sched (
    .clk     (clk),
    .ctrl    (sctrl),
    .byte_in (byte_sel),
    .w       (w)
  );

  sha1h_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cctrl),
    .rnd  (rnd),
    .w    (w),
    .sum  (sum)
  );

  // output register: hold the digest until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_a <= sum[0];
      digest_b <= sum[1];
      digest_c <= sum[2];
      digest_d <= sum[3];
      digest_e <= sum[4];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sha1h_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_checker: port-level checks of the SHA-1 hasher
// Watches the handshakes and the busy period after an end-of-message word.
// ----------------------------------------------------------------------------
module sha1h_checker import sha1h_pkg::*; (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        last,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] digest_a,
  input wire [31:0] digest_e
);

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_a) && $stable(digest_e))
    else $error("digest changed while stalled");

  // reset drops any pending digest
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

  // an end-of-message word starts padding: no input taken next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input accepted during padding");

  // a digest only appears out of a compression, never from idle
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("digest appeared without a compression");

endmodule

bind sha1_hasher sha1h_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .digest_a  (digest_a),
  .digest_e  (digest_e)
);
`default_nettype wire
